// ===== design/llsel_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llsel_pkg: shared types for the least loaded selector
// Command and status groups between the controller and the datapath,
// plus the fixed field widths of the request and result ports.
// ----------------------------------------------------------------------------
package llsel_pkg;

    // width of the target, chosen and server count fields
    localparam int unsigned FIELD_W = 5;

    // reset value of the server count register
    localparam logic [FIELD_W-1:0] SERVERS_RESET = 5'd16;

    // controller to datapath commands
    typedef struct packed {
        logic start;   // capture request, set up the scan range
        logic rd;      // read one count and step the address
        logic wb;      // write back the winning count and send the result
        logic err;     // send the out-of-range result
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic start_bad;   // request on the input names a server out of range
        logic last_rd;     // the current read address is the last of the range
    } t_dp_status;

endpackage
`default_nettype wire

// ===== design/llsel_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llsel_ctrl: request sequencer
// One-hot state machine that walks a request through the count scan,
// the compare drain and the write back, or straight to an error result.
// ----------------------------------------------------------------------------
module llsel_ctrl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire llsel_pkg::t_dp_status  i_status,
    output llsel_pkg::t_dp_cmd          o_cmd
);
    import llsel_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_WB    = 5'b01000,
        S_ERR   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command decode
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_status.start_bad ? S_ERR : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_status.last_rd) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_IDLE;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== design/llsel_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llsel_datapath: count memory, shared comparator and result register
// Holds the per-server load counts, scans a range of them one read per
// cycle keeping the lowest, and writes the saturated increment back.
// ----------------------------------------------------------------------------
module llsel_datapath #(
    parameter int unsigned MAX_SERVERS = 16,
    parameter int unsigned COUNT_BITS  = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire llsel_pkg::t_dp_cmd           i_cmd,
    output llsel_pkg::t_dp_status             o_status,
    input  wire [llsel_pkg::FIELD_W-1:0]      i_target,
    input  wire                               i_cfg_valid,
    input  wire [llsel_pkg::FIELD_W-1:0]      i_cfg_data,
    output logic                              o_valid,
    output logic [llsel_pkg::FIELD_W-1:0]     o_chosen,
    output logic                              o_bad_target
);
    import llsel_pkg::*;

    localparam int unsigned IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    // configuration and count storage
    logic [FIELD_W-1:0]    r_siu;
    logic [COUNT_BITS-1:0] r_mem [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] r_vld;

    // scan control
    logic [IW-1:0]         r_addr;
    logic [IW-1:0]         r_hi;
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_idx;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_first;
    logic [COUNT_BITS-1:0] r_best;
    logic [IW-1:0]         r_pick;

    // result register
    logic                  r_out_vld;
    logic [FIELD_W-1:0]    r_chosen;
    logic                  r_bad;

    // request decode
    logic [31:0]           eff_cnt;
    logic [IW-1:0]         last_idx;
    logic [IW-1:0]         named_idx;
    logic [IW-1:0]         lo;
    logic [IW-1:0]         hi;
    logic [COUNT_BITS-1:0] bumped;

    // effective server count, clamped to one and to the storage depth
    always_comb begin
        if (r_siu == '0) begin
            eff_cnt  = 32'd1;
            last_idx = '0;
        end else if (32'(r_siu) > MAX_SERVERS) begin
            eff_cnt  = MAX_SERVERS;
            last_idx = IW'(MAX_SERVERS - 1);
        end else begin
            eff_cnt  = 32'(r_siu);
            last_idx = IW'(r_siu - 5'd1);
        end
    end

    // scan range: the whole active set, or just the named server
    assign named_idx = IW'(i_target - 5'd1);
    assign lo        = (i_target == '0) ? '0 : named_idx;
    assign hi        = (i_target == '0) ? last_idx : named_idx;

    assign o_status.start_bad = (i_target != '0) && (32'(i_target) > eff_cnt);
    assign o_status.last_rd   = (r_addr == r_hi);

    // saturating increment of the winner
    assign bumped = (r_best == '1) ? r_best : r_best + COUNT_BITS'(1);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_siu <= SERVERS_RESET;
        end else if (i_cfg_valid) begin
            r_siu <= i_cfg_data;
        end
    end

    // count memory, entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_vld[r_addr] ? r_mem[r_addr] : '0;
        end
        if (i_cmd.wb) begin
            r_mem[r_pick] <= bumped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wb) begin
            r_vld[r_pick] <= 1'b1;
        end
    end

    // scan address and read tracking
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr <= lo;
            r_hi   <= hi;
        end else if (i_cmd.rd) begin
            r_addr <= r_addr + IW'(1);
        end
        r_rd_idx <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
        end
    end

    // shared comparator, strict less keeps the lowest index on ties
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_first <= 1'b1;
        end else if (r_rd_vld) begin
            r_first <= 1'b0;
            if (r_first || (r_rd_data < r_best)) begin
                r_best <= r_rd_data;
                r_pick <= r_rd_idx;
            end
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.wb | i_cmd.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err) begin
            r_chosen <= '0;
            r_bad    <= 1'b1;
        end else if (i_cmd.wb) begin
            r_chosen <= FIELD_W'(r_pick) + 5'd1;
            r_bad    <= 1'b0;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_chosen     = r_chosen;
    assign o_bad_target = r_bad;

endmodule
`default_nettype wire

// ===== design/least_loaded_selector_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// least_loaded_selector_core: least loaded server selector
// Sequence: a pick request reads the counts of the N active servers, one
//   count memory read per cycle into the single shared compare, then drains
//   it and writes back; a named server reads only its own count, a bad one
//   goes straight to the error beat. No new request is taken until idle.
// Reset: synchronous, clears all counts to zero and the server count to 16;
//   the result beat cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module least_loaded_selector_core #(
    parameter int unsigned MAX_SERVERS = 16,
    parameter int unsigned COUNT_BITS  = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire [llsel_pkg::FIELD_W-1:0]   i_target,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [llsel_pkg::FIELD_W-1:0]   i_cfg_data,
    output logic                           o_valid,
    output logic [llsel_pkg::FIELD_W-1:0]  o_chosen,
    output logic                           o_bad_target
);
    import llsel_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    llsel_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // counts, comparator and result
    llsel_datapath #(
        .MAX_SERVERS (MAX_SERVERS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_target     (i_target),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_chosen     (o_chosen),
        .o_bad_target (o_bad_target)
    );

    // a taken request always makes the block busy in the cycle after
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken without going busy");

    // one beat per request, never two in a row
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back to back result beats");

    // an out-of-range result reports no server
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_target) |-> (o_chosen == '0))
        else $error("error beat names a server");

    // the beat goes out once the sequencer has returned to idle
    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while still busy");

endmodule
`default_nettype wire
